// ----- rtl/sma_pkg.sv -----
// Shared types, codes and widths for the stack machine arithmetic unit.
`timescale 1ns / 1ps

package sma_pkg;

  localparam int WORD_W              = 32;
  localparam int ACTION_W            = 3;
  localparam int DEPTH_OUT_W         = 7;
  localparam int STACK_DEPTH_DEFAULT = 64;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_PUSH = 3'd0;
  localparam action_t ACT_SWAP = 3'd1;
  localparam action_t ACT_ADD  = 3'd2;
  localparam action_t ACT_SUB  = 3'd3;
  localparam action_t ACT_DIV  = 3'd4;
  localparam action_t ACT_MUL  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // What the datapath commits to the stack in a cycle
  typedef enum logic [2:0] {
    CM_NONE,
    CM_PUSH,
    CM_SWAP,
    CM_ADD,
    CM_SUB,
    CM_MUL,
    CM_DIV
  } commit_t;

  typedef struct packed {
    logic    load_item;
    commit_t commit;
    logic    div_start;
    logic    load_out;
    status_t out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    short_stack;
    logic    top_zero;
    logic    div_done;
  } dp_stat_t;

endpackage

// ----- rtl/sma_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module sma_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sma_pkg::WORD_W-1:0] num,
  input  logic [sma_pkg::WORD_W-1:0] den,
  output logic                      done,
  output logic [sma_pkg::WORD_W-1:0] quot
);

  localparam int W     = sma_pkg::WORD_W;
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dmag;
  logic             neg;

  logic [W-1:0] rem_sh;
  logic         ge;

  // rem stays below dmag <= 2^(W-1), so its top bit is always clear
  assign rem_sh = {rem[W-2:0], quo[W-1]};
  assign ge     = (rem_sh >= dmag);
  assign quot   = neg ? (W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num[W-1] ? (W'(0) - num) : num;
      dmag <= den[W-1] ? (W'(0) - den) : den;
      neg  <= num[W-1] ^ den[W-1];
    end else if (busy) begin
      rem <= ge ? (rem_sh - dmag) : rem_sh;
      quo <= {quo[W-2:0], ge};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");

endmodule

// ----- rtl/sma_ctrl.sv -----
// Controller state machine: sequences decode, arithmetic, commit and result hand-off.
`timescale 1ns / 1ps

module sma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  sma_pkg::dp_stat_t  stat,
  output sma_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t           state;
  state_t           state_next;
  sma_pkg::status_t status_q;
  sma_pkg::status_t status_next;
  logic             slot_free;

  assign s_tready  = (state == S_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    state_next     = state;
    status_next    = status_q;
    cmd            = '0;
    cmd.commit     = sma_pkg::CM_NONE;
    cmd.out_status = status_q;
    unique case (state)
      S_IDLE: begin
        cmd.load_item = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        status_next = sma_pkg::ST_OK;
        state_next  = S_FINISH;
        unique case (stat.action) inside
          sma_pkg::ACT_PUSH: begin
            if (stat.full) begin
              status_next = sma_pkg::ST_FULL;
            end else begin
              cmd.commit = sma_pkg::CM_PUSH;
            end
          end
          sma_pkg::ACT_SWAP, sma_pkg::ACT_ADD, sma_pkg::ACT_SUB,
          sma_pkg::ACT_DIV, sma_pkg::ACT_MUL: begin
            if (stat.short_stack) begin
              status_next = sma_pkg::ST_SHORT;
            end else begin
              unique case (stat.action)
                sma_pkg::ACT_SWAP: cmd.commit = sma_pkg::CM_SWAP;
                sma_pkg::ACT_ADD:  cmd.commit = sma_pkg::CM_ADD;
                sma_pkg::ACT_SUB:  cmd.commit = sma_pkg::CM_SUB;
                sma_pkg::ACT_MUL:  state_next = S_MUL;
                default: begin
                  if (stat.top_zero) begin
                    status_next = sma_pkg::ST_DIVZERO;
                  end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                  end
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        cmd.commit = sma_pkg::CM_MUL;
        state_next = S_FINISH;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.commit = sma_pkg::CM_DIV;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= sma_pkg::ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      status_q <= status_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready |=> state == S_DECODE)
    else $error("accepted word not decoded");
  assert property (@(posedge clk) disable iff (rst)
      cmd.load_out |=> m_tvalid && state == S_IDLE)
    else $error("result not presented after load");
  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before it was taken");

endmodule

// ----- rtl/sma_dpath.sv -----
// Datapath: stack memory, cached top entry, adder, multiplier, divider and result register.
`timescale 1ns / 1ps

module sma_dpath #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sma_pkg::ctrl_cmd_t             cmd,
  input  logic [sma_pkg::ACTION_W-1:0]   action_in,
  input  logic [sma_pkg::WORD_W-1:0]     value_in,
  output sma_pkg::dp_stat_t              stat,
  output logic [1:0]                     out_status,
  output logic [sma_pkg::WORD_W-1:0]     out_top,
  output logic [sma_pkg::DEPTH_OUT_W-1:0] out_depth
);

  localparam int W  = sma_pkg::WORD_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // The top entry lives in top_q; the memory holds the entries beneath it.
  logic [W-1:0]        mem [STACK_DEPTH];
  logic [CW-1:0]       count;
  logic [W-1:0]        top_q;
  logic [W-1:0]        rd_data;
  logic [W-1:0]        prod_q;
  sma_pkg::action_t    action_q;
  logic [W-1:0]        value_q;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic          wr_en;
  logic [W-1:0]  quot;
  logic          div_done;

  assign rd_addr = AW'(count - CW'(2));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = top_q;
    unique case (cmd.commit)
      sma_pkg::CM_PUSH: begin
        wr_en   = (count != '0);
        wr_addr = AW'(count - CW'(1));
      end
      sma_pkg::CM_SWAP: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod_q <= rd_data * top_q;
    if (cmd.load_item) begin
      action_q <= action_in;
      value_q  <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.commit)
        sma_pkg::CM_PUSH: count <= count + CW'(1);
        sma_pkg::CM_ADD, sma_pkg::CM_SUB,
        sma_pkg::CM_MUL, sma_pkg::CM_DIV: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.commit)
      sma_pkg::CM_PUSH: top_q <= value_q;
      sma_pkg::CM_SWAP: top_q <= rd_data;
      sma_pkg::CM_ADD:  top_q <= rd_data + top_q;
      sma_pkg::CM_SUB:  top_q <= rd_data - top_q;
      sma_pkg::CM_MUL:  top_q <= prod_q;
      sma_pkg::CM_DIV:  top_q <= quot;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.out_status;
      out_top    <= (count == '0) ? '0 : top_q;
      out_depth  <= sma_pkg::DEPTH_OUT_W'(count);
    end
  end

  sma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (rd_data),
    .den   (top_q),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.action      = action_q;
  assign stat.full        = (count == CW'(STACK_DEPTH));
  assign stat.short_stack = (count < CW'(2));
  assign stat.top_zero    = (top_q == '0);
  assign stat.div_done    = div_done;

  assert property (@(posedge clk) disable iff (rst) count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
      cmd.commit == sma_pkg::CM_PUSH |-> !stat.full)
    else $error("push committed onto a full stack");
  assert property (@(posedge clk) disable iff (rst)
      (cmd.commit == sma_pkg::CM_SWAP || cmd.commit == sma_pkg::CM_ADD ||
       cmd.commit == sma_pkg::CM_SUB || cmd.commit == sma_pkg::CM_MUL ||
       cmd.commit == sma_pkg::CM_DIV) |-> !stat.short_stack)
    else $error("two-operand commit with fewer than two entries");
  assert property (@(posedge clk) disable iff (rst)
      cmd.commit == sma_pkg::CM_NONE |=> $stable(count))
    else $error("stack count moved without a commit");

endmodule

// ----- rtl/stack_machine_arith_unit.sv -----
// Top level of the stack machine arithmetic unit: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Bounded operand stack of signed 32-bit entries driven by a word stream. Each
// input word pushes push_value or applies swap, add, sub, div or mul to the top
// two entries (second op top replaces the second entry, the top is popped);
// add, sub and mul wrap to 32 bits and div truncates toward zero. Every input
// word gives exactly one result word: a status (ok, too short, divide by zero,
// full), the new top entry (zero when empty) and the new depth (low 7 bits of
// the count). On any error the stack is left as it was; actions 6 and 7 leave it
// untouched with status ok. One word is worked on at a time: push, swap, add,
// sub, errors and unknown actions go through the decode and finish states; mul
// also passes the mul state for the registered multiplier, and div waits in the
// div state for the divider, which makes one quotient bit per cycle. The next
// input word is taken while a result still waits in the output register; a
// result stalls only when the previous one has not yet been taken. The stack
// store needs no clearing after reset: only entries below the count are used.

module stack_machine_arith_unit #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: [2:0] action, [34:3] push_value, [39:35] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // m_tdata: [1:0] status, [33:2] top_value, [40:34] depth, [47:41] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata
);

  sma_pkg::ctrl_cmd_t cmd;
  sma_pkg::dp_stat_t  stat;

  logic [1:0]                      out_status;
  logic [sma_pkg::WORD_W-1:0]      out_top;
  logic [sma_pkg::DEPTH_OUT_W-1:0] out_depth;

  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sma_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .action_in  (s_tdata[2:0]),
    .value_in   (s_tdata[34:3]),
    .stat       (stat),
    .out_status (out_status),
    .out_top    (out_top),
    .out_depth  (out_depth)
  );

  // Result word packed lowest field first, padded to whole bytes
  assign m_tdata = {7'b0, out_depth, out_top, out_status};

endmodule
